// ----- src/trd_pkg.sv -----
// shared types and constants of the truecolor tga rle pixel decoder
package trd_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] TYPE_RAW = 8'd2;
	localparam logic [7:0] TYPE_RLE = 8'd10;
	localparam logic [7:0] BPP_24 = 8'd24;
	localparam logic [7:0] BPP_32 = 8'd32;
	localparam logic [18:0] SKIP_MAX = 19'h7FFFF;

	localparam logic [4:0] HDR_ID_LEN = 5'd0;
	localparam logic [4:0] HDR_TYPE = 5'd2;
	localparam logic [4:0] HDR_CM_LEN_LO = 5'd5;
	localparam logic [4:0] HDR_CM_LEN_HI = 5'd6;
	localparam logic [4:0] HDR_CM_BITS = 5'd7;
	localparam logic [4:0] HDR_SKIP_CALC = 5'd8;
	localparam logic [4:0] HDR_WIDTH_LO = 5'd12;
	localparam logic [4:0] HDR_WIDTH_HI = 5'd13;
	localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
	localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
	localparam logic [4:0] HDR_BPP = 5'd16;
	localparam logic [4:0] HDR_LAST = 5'd17;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_SKIP   = 5'b00010,
		PH_PACKET = 5'b00100,
		PH_PIXEL  = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [7:0] alpha;
		logic [7:0] repeat_count;
		logic       last_pixel;
		logic       format_error;
	} trd_result_t;

endpackage

// ----- src/tga_rle_pixel_decoder.sv -----
// top level of the truecolor tga rle pixel decoder
//  channel  direction  handshake             payload
//  in       input      in_valid / in_ready   data_byte, file_start
//  out      output     out_valid / out_ready blue, green, red, alpha, repeat_count,
//                                            last_pixel, format_error
// one file byte is taken per cycle while in_ready is high; the parser updates its state in that cycle
// a result goes from the parser through a four-item queue and then the output register to out_valid
// in_ready falls only while the queue is full; out stalls back up through it
// reset puts the parser in the header phase with an empty queue and output
module tga_rle_pixel_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       file_start,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] blue,
	output logic [7:0] green,
	output logic [7:0] red,
	output logic [7:0] alpha,
	output logic [7:0] repeat_count,
	output logic       last_pixel,
	output logic       format_error
);

	logic                 take;
	logic                 res_valid;
	trd_pkg::trd_result_t res;
	trd_pkg::trd_result_t q_head;
	logic                 q_not_empty;
	logic                 q_full;
	logic                 q_pop;
	trd_pkg::trd_result_t out_res;

	assign in_ready = !q_full;
	assign take = in_valid && in_ready;

	trd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (data_byte),
		.file_start (file_start),
		.res_valid  (res_valid),
		.res        (res)
	);

	trd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	trd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign blue = out_res.blue;
	assign green = out_res.green;
	assign red = out_res.red;
	assign alpha = out_res.alpha;
	assign repeat_count = out_res.repeat_count;
	assign last_pixel = out_res.last_pixel;
	assign format_error = out_res.format_error;

endmodule

// ----- src/trd_front.sv -----
// byte parser: header, skip, packet headers and pixel assembly
module trd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  logic [7:0]           data_byte,
	input  logic                 file_start,
	output logic                 res_valid,
	output trd_pkg::trd_result_t res
);

	trd_pkg::phase_t phase_q, phase_d, phase_cur;
	logic [4:0]  hidx_q, hidx_d, hidx_cur;
	logic [7:0]  id_len_q, id_len_d;
	logic [7:0]  img_type_q, img_type_d;
	logic [15:0] cm_entries_q, cm_entries_d;
	logic [7:0]  cm_bits_q, cm_bits_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [7:0]  bpp_q, bpp_d;
	logic [18:0] skip_q, skip_d;
	logic [31:0] pix_rem_q, pix_rem_d;
	logic        run_q, run_d;
	logic [7:0]  pkt_left_q, pkt_left_d;
	logic [1:0]  byte_idx_q, byte_idx_d;
	logic [23:0] asm_q, asm_d;

	logic        emit;
	logic        is_rle;
	logic        is_32;
	logic [1:0]  last_idx;
	logic [5:0]  entry_bytes;
	logic [8:0]  cm_bits_round;
	logic [22:0] skip_full;
	logic [7:0]  cnt_raw;
	logic [31:0] cnt_raw_ext;
	logic [7:0]  cnt;
	logic        reach_end;
	logic [7:0]  left_next;
	logic        fmt_ok;

	assign is_rle = (img_type_q == trd_pkg::TYPE_RLE);
	assign is_32 = (bpp_q == trd_pkg::BPP_32);
	assign last_idx = is_32 ? 2'd3 : 2'd2;
	assign cm_bits_round = {1'b0, cm_bits_q} + 9'd7;
	assign entry_bytes = cm_bits_round[8:3];
	assign skip_full = {7'd0, cm_entries_q} * {17'd0, entry_bytes} + {15'd0, id_len_q};
	assign fmt_ok = ((bpp_q == trd_pkg::BPP_24) || (bpp_q == trd_pkg::BPP_32))
		&& ((img_type_q == trd_pkg::TYPE_RAW) || (img_type_q == trd_pkg::TYPE_RLE));
	assign cnt_raw = (is_rle && run_q) ? pkt_left_q : 8'd1;
	assign cnt_raw_ext = {24'd0, cnt_raw};
	assign reach_end = (cnt_raw_ext >= pix_rem_q);
	assign cnt = reach_end ? pix_rem_q[7:0] : cnt_raw;
	assign left_next = run_q ? 8'd0 : pkt_left_q - 8'd1;
	assign phase_cur = file_start ? trd_pkg::PH_HEADER : phase_q;
	assign hidx_cur = file_start ? 5'd0 : hidx_q;

	always_comb begin
		phase_d = phase_cur;
		hidx_d = hidx_cur;
		id_len_d = id_len_q;
		img_type_d = img_type_q;
		cm_entries_d = cm_entries_q;
		cm_bits_d = cm_bits_q;
		width_d = width_q;
		height_d = height_q;
		bpp_d = bpp_q;
		skip_d = skip_q;
		pix_rem_d = pix_rem_q;
		run_d = run_q;
		pkt_left_d = pkt_left_q;
		byte_idx_d = byte_idx_q;
		asm_d = asm_q;
		emit = 1'b0;
		res = '0;
		unique case (phase_cur)
			trd_pkg::PH_HEADER: begin
				priority case (hidx_cur)
					trd_pkg::HDR_ID_LEN: id_len_d = data_byte;
					trd_pkg::HDR_TYPE: img_type_d = data_byte;
					trd_pkg::HDR_CM_LEN_LO: cm_entries_d[7:0] = data_byte;
					trd_pkg::HDR_CM_LEN_HI: cm_entries_d[15:8] = data_byte;
					trd_pkg::HDR_CM_BITS: cm_bits_d = data_byte;
					trd_pkg::HDR_SKIP_CALC: begin
						skip_d = (skip_full > {4'd0, trd_pkg::SKIP_MAX}) ?
							trd_pkg::SKIP_MAX : skip_full[18:0];
					end
					trd_pkg::HDR_WIDTH_LO: width_d[7:0] = data_byte;
					trd_pkg::HDR_WIDTH_HI: width_d[15:8] = data_byte;
					trd_pkg::HDR_HEIGHT_LO: height_d[7:0] = data_byte;
					trd_pkg::HDR_HEIGHT_HI: height_d[15:8] = data_byte;
					trd_pkg::HDR_BPP: begin
						bpp_d = data_byte;
						pix_rem_d = {16'd0, width_q} * {16'd0, height_q};
					end
					default: ;
				endcase
				if (hidx_cur >= trd_pkg::HDR_LAST) begin
					hidx_d = 5'd0;
					if (!fmt_ok) begin
						emit = 1'b1;
						res.format_error = 1'b1;
						phase_d = trd_pkg::PH_DONE;
					end else begin
						run_d = 1'b0;
						pkt_left_d = 8'd0;
						byte_idx_d = 2'd0;
						if (skip_q != 19'd0) begin
							phase_d = trd_pkg::PH_SKIP;
						end else if (pix_rem_q == 32'd0) begin
							phase_d = trd_pkg::PH_DONE;
						end else begin
							phase_d = is_rle ? trd_pkg::PH_PACKET : trd_pkg::PH_PIXEL;
						end
					end
				end else begin
					hidx_d = hidx_cur + 5'd1;
				end
			end
			trd_pkg::PH_SKIP: begin
				if (skip_q != 19'd0) begin
					skip_d = skip_q - 19'd1;
				end
				if (skip_q <= 19'd1) begin
					byte_idx_d = 2'd0;
					if (pix_rem_q == 32'd0) begin
						phase_d = trd_pkg::PH_DONE;
					end else begin
						phase_d = is_rle ? trd_pkg::PH_PACKET : trd_pkg::PH_PIXEL;
					end
				end
			end
			trd_pkg::PH_PACKET: begin
				run_d = data_byte[7];
				pkt_left_d = {1'b0, data_byte[6:0]} + 8'd1;
				byte_idx_d = 2'd0;
				phase_d = trd_pkg::PH_PIXEL;
			end
			trd_pkg::PH_PIXEL: begin
				if (byte_idx_q < last_idx) begin
					unique case (byte_idx_q)
						2'd0: asm_d[7:0] = data_byte;
						2'd1: asm_d[15:8] = data_byte;
						default: asm_d[23:16] = data_byte;
					endcase
					byte_idx_d = byte_idx_q + 2'd1;
				end else begin
					emit = 1'b1;
					res.blue = asm_q[7:0];
					res.green = asm_q[15:8];
					res.red = (byte_idx_q == 2'd2) ? data_byte : asm_q[23:16];
					res.alpha = is_32 ? data_byte : 8'd0;
					res.repeat_count = cnt;
					res.last_pixel = reach_end;
					pix_rem_d = pix_rem_q - {24'd0, cnt};
					byte_idx_d = 2'd0;
					if (is_rle) begin
						pkt_left_d = left_next;
					end
					if (reach_end) begin
						phase_d = trd_pkg::PH_DONE;
					end else if (is_rle && (left_next == 8'd0)) begin
						phase_d = trd_pkg::PH_PACKET;
					end
				end
			end
			trd_pkg::PH_DONE: ;
			default: phase_d = trd_pkg::PH_DONE;
		endcase
	end

	assign res_valid = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= trd_pkg::PH_HEADER;
			hidx_q <= 5'd0;
		end else if (take) begin
			phase_q <= phase_d;
			hidx_q <= hidx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			id_len_q <= id_len_d;
			img_type_q <= img_type_d;
			cm_entries_q <= cm_entries_d;
			cm_bits_q <= cm_bits_d;
			width_q <= width_d;
			height_q <= height_d;
			bpp_q <= bpp_d;
			skip_q <= skip_d;
			pix_rem_q <= pix_rem_d;
			run_q <= run_d;
			pkt_left_q <= pkt_left_d;
			byte_idx_q <= byte_idx_d;
			asm_q <= asm_d;
		end
	end

	// a final pixel or an error leaves the parser done
	a_end_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.last_pixel || res.format_error))
		|=> (phase_q == trd_pkg::PH_DONE))
		else $error("parser not done after final item");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.format_error)
		|-> ((res.repeat_count != 8'd0) && (res.repeat_count <= 8'd128)))
		else $error("repeat count out of range");

	a_fourth_byte: assert property (@(posedge clk) disable iff (!arst_n)
		((phase_q == trd_pkg::PH_PIXEL) && (byte_idx_q == 2'd3)) |-> is_32)
		else $error("fourth pixel byte on a 24-bit image");

endmodule

// ----- src/trd_queue.sv -----
// short result queue between parser and output stage
module trd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  trd_pkg::trd_result_t push_data,
	input  logic                 pop,
	output trd_pkg::trd_result_t head,
	output logic                 not_empty,
	output logic                 full
);

	trd_pkg::trd_result_t entry_q [trd_pkg::QUEUE_DEPTH];
	logic [trd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [trd_pkg::QUEUE_CNT_W-1:0] count_q;

	localparam logic [trd_pkg::QUEUE_CNT_W-1:0] DEPTH_C =
		trd_pkg::QUEUE_CNT_W'(trd_pkg::QUEUE_DEPTH);
	localparam logic [trd_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
		trd_pkg::QUEUE_PTR_W'(trd_pkg::QUEUE_DEPTH - 1);
	localparam logic [trd_pkg::QUEUE_PTR_W-1:0] PTR_ONE = trd_pkg::QUEUE_PTR_W'(1);
	localparam logic [trd_pkg::QUEUE_CNT_W-1:0] CNT_ONE = trd_pkg::QUEUE_CNT_W'(1);

	assign not_empty = (count_q != '0);
	assign full = (count_q == DEPTH_C);
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_ONE;
			end else if (pop && !push) begin
				count_q <= count_q - CNT_ONE;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue underflow");

endmodule

// ----- src/trd_back.sv -----
// output register that presents one result item at a time
module trd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	input  trd_pkg::trd_result_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output trd_pkg::trd_result_t out_res
);

	logic                 valid_q;
	trd_pkg::trd_result_t res_q;
	logic                 load;

	assign load = !valid_q || out_ready;
	assign q_pop = q_valid && load;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			res_q <= q_head;
		end
	end

endmodule

// ----- tb/sv/tb.sv -----
// testbench for the tga rle pixel decoder: byte stream files against a cycle-free decode model
module tb;

	localparam int unsigned RANDOM_ITEMS = 260;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned MAX_REPORTS = 40;
	localparam int unsigned HUGE_TAIL = 240;
	localparam logic [7:0] TYPE_GRAY = 8'd3;
	localparam trd_pkg::trd_result_t NO_RES = '0;
	localparam trd_pkg::trd_result_t FMT_ERR = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1};

	typedef enum {
		FILE_RANDOM,
		FILE_DENSE,
		FILE_HUGE_SKIP
	} file_kind_t;

	typedef struct {
		logic [7:0]           data;
		logic                 start;
		bit                   own;
		bit                   own_has;
		trd_pkg::trd_result_t own_res;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'd0;
	logic        file_start = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [7:0]  blue;
	logic [7:0]  green;
	logic [7:0]  red;
	logic [7:0]  alpha;
	logic [7:0]  repeat_count;
	logic        last_pixel;
	logic        format_error;

	// decode model state
	trd_pkg::phase_t pred_phase;
	logic [4:0]  hdr_idx;
	logic [7:0]  id_len;
	logic [7:0]  img_type;
	logic [15:0] cm_entries;
	logic [7:0]  cm_bits;
	logic [15:0] img_w;
	logic [15:0] img_h;
	logic [7:0]  bpp;
	logic [18:0] skip_left;
	logic [31:0] pix_left;
	logic        run_pkt;
	logic [7:0]  pkt_left;
	logic [1:0]  byte_pos;
	logic [31:0] pix_acc;

	trd_pkg::trd_result_t pending_px[$];
	trd_pkg::trd_result_t want;
	logic [7:0]  file_bytes[$];
	int unsigned errors = 0;
	int unsigned checked = 0;
	int unsigned quiet = 0;
	int unsigned src_idle = 34;
	int unsigned dst_idle = 76;
	logic        hold_req = 1'b0;
	logic        hold_seen = 1'b0;

	// partial header, then an unsupported type, then bytes after the error
	stim_row_t directed_rows [23] = '{
		'{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{trd_pkg::TYPE_RLE, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b1, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
		'{TYPE_GRAY, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h5A, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'hA5, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h18, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h02, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h01, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES},
		'{trd_pkg::BPP_32, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h20, 1'b0, 1'b1, 1'b1, FMT_ERR},
		'{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
		'{8'h00, 1'b0, 1'b1, 1'b0, NO_RES}
	};

	tga_rle_pixel_decoder u_top (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic parser_clear();
		pred_phase = trd_pkg::PH_HEADER;
		hdr_idx    = '0;
		id_len     = '0;
		img_type   = '0;
		cm_entries = '0;
		cm_bits    = '0;
		img_w      = '0;
		img_h      = '0;
		bpp        = '0;
		skip_left  = '0;
		pix_left   = '0;
		run_pkt    = 1'b0;
		pkt_left   = '0;
		byte_pos   = '0;
		pix_acc    = '0;
	endtask

	task automatic enter_pixels();
		if (pix_left == 32'd0)
			pred_phase = trd_pkg::PH_DONE;
		else if (img_type == trd_pkg::TYPE_RLE)
			pred_phase = trd_pkg::PH_PACKET;
		else
			pred_phase = trd_pkg::PH_PIXEL;
		byte_pos = 2'd0;
		pix_acc  = 32'd0;
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic fs, output logic got,
			output trd_pkg::trd_result_t r);
		logic [63:0] skip;
		logic [31:0] cnt;
		logic [1:0]  last_pos;
		got = 1'b0;
		r   = '0;
		if (fs)
			parser_clear();
		case (pred_phase)
			trd_pkg::PH_HEADER: begin
				case (hdr_idx)
					trd_pkg::HDR_ID_LEN:    id_len = b;
					trd_pkg::HDR_TYPE:      img_type = b;
					trd_pkg::HDR_CM_LEN_LO: cm_entries[7:0] = b;
					trd_pkg::HDR_CM_LEN_HI: cm_entries[15:8] = b;
					trd_pkg::HDR_CM_BITS:   cm_bits = b;
					trd_pkg::HDR_WIDTH_LO:  img_w[7:0] = b;
					trd_pkg::HDR_WIDTH_HI:  img_w[15:8] = b;
					trd_pkg::HDR_HEIGHT_LO: img_h[7:0] = b;
					trd_pkg::HDR_HEIGHT_HI: img_h[15:8] = b;
					trd_pkg::HDR_BPP:       bpp = b;
					default: ;
				endcase
				if (hdr_idx >= trd_pkg::HDR_LAST) begin
					hdr_idx = '0;
					if (!(bpp == trd_pkg::BPP_24 || bpp == trd_pkg::BPP_32) ||
							!(img_type == trd_pkg::TYPE_RAW ||
							img_type == trd_pkg::TYPE_RLE)) begin
						got = 1'b1;
						r.format_error = 1'b1;
						pred_phase = trd_pkg::PH_DONE;
					end else begin
						skip = 64'(id_len) + 64'(cm_entries) * ((64'(cm_bits) + 64'd7) >> 3);
						skip_left = (skip > 64'(trd_pkg::SKIP_MAX)) ?
							trd_pkg::SKIP_MAX : skip[18:0];
						pix_left = 32'(img_w) * 32'(img_h);
						run_pkt = 1'b0;
						pkt_left = 8'd0;
						if (skip_left != '0)
							pred_phase = trd_pkg::PH_SKIP;
						else
							enter_pixels();
					end
				end else begin
					hdr_idx = hdr_idx + 5'd1;
				end
			end
			trd_pkg::PH_SKIP: begin
				if (skip_left != '0)
					skip_left = skip_left - 19'd1;
				if (skip_left == '0)
					enter_pixels();
			end
			trd_pkg::PH_PACKET: begin
				run_pkt    = b[7];
				pkt_left   = {1'b0, b[6:0]} + 8'd1;
				byte_pos   = 2'd0;
				pix_acc    = 32'd0;
				pred_phase = trd_pkg::PH_PIXEL;
			end
			trd_pkg::PH_PIXEL: begin
				last_pos = (bpp == trd_pkg::BPP_32) ? 2'd3 : 2'd2;
				pix_acc  = pix_acc | (32'(b) << (8 * byte_pos));
				if (byte_pos < last_pos) begin
					byte_pos = byte_pos + 2'd1;
				end else begin
					cnt = (img_type == trd_pkg::TYPE_RLE && run_pkt) ? 32'(pkt_left) : 32'd1;
					if (cnt > pix_left)
						cnt = pix_left;
					got            = 1'b1;
					r.blue         = pix_acc[7:0];
					r.green        = pix_acc[15:8];
					r.red          = pix_acc[23:16];
					r.alpha        = (last_pos == 2'd3) ? pix_acc[31:24] : 8'd0;
					r.repeat_count = cnt[7:0];
					pix_left       = pix_left - cnt;
					byte_pos       = 2'd0;
					pix_acc        = 32'd0;
					if (img_type == trd_pkg::TYPE_RLE)
						pkt_left = run_pkt ? 8'd0 : pkt_left - 8'd1;
					if (pix_left == 32'd0) begin
						r.last_pixel = 1'b1;
						pred_phase   = trd_pkg::PH_DONE;
					end else if (img_type == trd_pkg::TYPE_RLE && pkt_left == 8'd0) begin
						pred_phase = trd_pkg::PH_PACKET;
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b, input logic fs, input bit own,
			input bit own_has, input trd_pkg::trd_result_t own_res);
		logic                 got;
		trd_pkg::trd_result_t res;
		while ($urandom_range(0, 99) < src_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		data_byte  <= b;
		file_start <= fs;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decode_byte(b, fs, got, res);
		if (own) begin
			got = own_has;
			res = own_res;
		end
		if (got)
			pending_px.push_back(res);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_px.size() != 0);
	endtask

	task automatic build_file(input file_kind_t kind, output int unsigned nbytes);
		logic [7:0]  ty;
		logic [7:0]  bp;
		logic [7:0]  cm_b;
		logic [7:0]  id;
		logic [15:0] w;
		logic [15:0] h;
		logic [15:0] cm_n;
		int unsigned pick;
		int unsigned skip;
		int unsigned left;
		int unsigned n;
		int unsigned m;
		int unsigned px_bytes;
		bit          run;
		bit          fmt_ok;
		bit          long_img;
		bit          dims_huge;
		file_bytes.delete();
		pick      = $urandom_range(0, 99);
		ty        = $urandom_range(0, 1) ? trd_pkg::TYPE_RLE : trd_pkg::TYPE_RAW;
		bp        = $urandom_range(0, 1) ? trd_pkg::BPP_32 : trd_pkg::BPP_24;
		id        = ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(1, 6));
		cm_n      = ($urandom_range(0, 9) < 7) ? 16'd0 : 16'($urandom_range(1, 3));
		cm_b      = 8'($urandom);
		w         = 16'($urandom_range(1, 6));
		h         = 16'($urandom_range(1, 4));
		long_img  = 1'b0;
		dims_huge = 1'b0;
		if (pick < 4) begin
			ty = 8'($urandom);
		end else if (pick < 8) begin
			bp = 8'($urandom);
		end else if (pick < 12) begin
			w = 16'd0;
			h = 16'($urandom);
		end else if (pick < 16) begin
			h = 16'd0;
			w = 16'($urandom);
		end else if (pick < 24) begin
			w = 16'($urandom);
			h = 16'($urandom);
			dims_huge = 1'b1;
		end else if (pick < 36 && ty == trd_pkg::TYPE_RLE) begin
			w = 16'($urandom_range(1, 255));
			h = 16'd1;
			long_img = 1'b1;
		end else if (pick < 40) begin
			id = 8'hFF;
		end
		if (kind == FILE_DENSE) begin
			ty        = trd_pkg::TYPE_RAW;
			bp        = trd_pkg::BPP_24;
			id        = 8'd0;
			cm_n      = 16'd0;
			w         = 16'd8;
			h         = 16'd3;
			long_img  = 1'b0;
			dims_huge = 1'b0;
		end else if (kind == FILE_HUGE_SKIP) begin
			// color map far past the skip ceiling, entry size rounds up to 32 bytes
			// only the first part of the color map is sent
			ty        = trd_pkg::TYPE_RLE;
			bp        = trd_pkg::BPP_32;
			id        = 8'hFF;
			cm_n      = 16'hFFFF;
			cm_b      = 8'hFF;
			w         = 16'd2;
			h         = 16'd1;
			long_img  = 1'b0;
			dims_huge = 1'b0;
		end
		for (int k = 0; k < 18; k++)
			file_bytes.push_back(8'($urandom));
		file_bytes[trd_pkg::HDR_ID_LEN]    = id;
		file_bytes[trd_pkg::HDR_TYPE]      = ty;
		file_bytes[trd_pkg::HDR_CM_LEN_LO] = cm_n[7:0];
		file_bytes[trd_pkg::HDR_CM_LEN_HI] = cm_n[15:8];
		file_bytes[trd_pkg::HDR_CM_BITS]   = cm_b;
		file_bytes[trd_pkg::HDR_WIDTH_LO]  = w[7:0];
		file_bytes[trd_pkg::HDR_WIDTH_HI]  = w[15:8];
		file_bytes[trd_pkg::HDR_HEIGHT_LO] = h[7:0];
		file_bytes[trd_pkg::HDR_HEIGHT_HI] = h[15:8];
		file_bytes[trd_pkg::HDR_BPP]       = bp;
		fmt_ok = (ty == trd_pkg::TYPE_RAW || ty == trd_pkg::TYPE_RLE) &&
			(bp == trd_pkg::BPP_24 || bp == trd_pkg::BPP_32);
		if (fmt_ok) begin
			skip = 32'(id) + 32'(cm_n) * ((32'(cm_b) + 32'd7) >> 3);
			if (skip > trd_pkg::SKIP_MAX)
				skip = trd_pkg::SKIP_MAX;
			if (kind == FILE_HUGE_SKIP)
				skip = HUGE_TAIL;
			repeat (skip)
				file_bytes.push_back(8'($urandom));
			px_bytes = (bp == trd_pkg::BPP_32) ? 4 : 3;
			left = 32'(w) * 32'(h);
			if (dims_huge && left > 20)
				left = $urandom_range(4, 20);
			while (left > 0) begin
				m = 1;
				if (ty == trd_pkg::TYPE_RLE) begin
					run = long_img ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 1) != 0);
					if (run && (long_img || $urandom_range(0, 3) == 0))
						n = $urandom_range(1, 128);
					else
						n = $urandom_range(1, 8);
					file_bytes.push_back({run, 7'(n - 1)});
					if (n > left)
						n = left;
					m = run ? 1 : n;
					left -= n;
				end else begin
					left--;
				end
				repeat (m * px_bytes)
					file_bytes.push_back(8'($urandom));
			end
		end
		if (kind == FILE_RANDOM && !dims_huge && $urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3))
				file_bytes.push_back(8'($urandom));
		if (kind == FILE_RANDOM && $urandom_range(0, 11) == 0) begin
			n = $urandom_range(1, file_bytes.size() - 1);
			while (file_bytes.size() > n)
				void'(file_bytes.pop_back());
		end
		nbytes = file_bytes.size();
	endtask

	task automatic send_file(input logic first_start);
		foreach (file_bytes[i])
			push_byte(file_bytes[i], (i == 0) ? first_start : 1'b0, 1'b0, 1'b0, NO_RES);
	endtask

	task automatic report(input string msg);
		errors++;
		if (errors <= MAX_REPORTS)
			$display("tb: mismatch at result %0d: %s", checked, msg);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (hold_req && !hold_seen) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
				hold_seen = 1'b1;
			end
			out_ready <= ($urandom_range(0, 99) >= dst_idle);
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (pending_px.size() == 0) begin
				report("item with nothing expected");
			end else begin
				want = pending_px.pop_front();
				if (blue !== want.blue)
					report($sformatf("blue %0h, want %0h", blue, want.blue));
				if (green !== want.green)
					report($sformatf("green %0h, want %0h", green, want.green));
				if (red !== want.red)
					report($sformatf("red %0h, want %0h", red, want.red));
				if (alpha !== want.alpha)
					report($sformatf("alpha %0h, want %0h", alpha, want.alpha));
				if (repeat_count !== want.repeat_count)
					report($sformatf("repeat_count %0d, want %0d", repeat_count,
						want.repeat_count));
				if (last_pixel !== want.last_pixel)
					report($sformatf("last_pixel %b, want %b", last_pixel, want.last_pixel));
				if (format_error !== want.format_error)
					report($sformatf("format_error %b, want %b", format_error,
						want.format_error));
			end
			checked++;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tb: stalled, %0d results still expected", pending_px.size());
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		file_kind_t  kind;
		int unsigned sent;
		int unsigned n;
		int unsigned stage;
		parser_clear();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			push_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].own,
				directed_rows[i].own_has, directed_rows[i].own_res);
		sent  = 0;
		stage = 0;
		while (sent < RANDOM_ITEMS) begin
			kind = FILE_RANDOM;
			if (stage == 0 && sent >= RANDOM_ITEMS / 3) begin
				drain();
				src_idle = 76;
				dst_idle <= 34;
				stage = 1;
			end else if (stage == 1 && sent >= 2 * RANDOM_ITEMS / 3) begin
				drain();
				src_idle = 0;
				dst_idle <= 0;
				hold_req <= 1'b1;
				kind = FILE_DENSE;
				stage = 2;
			end
			build_file(kind, n);
			// now and then a file without its start mark, ignored after a finished file
			send_file(!(kind == FILE_RANDOM && pred_phase == trd_pkg::PH_DONE &&
				$urandom_range(0, 19) == 0));
			sent += n;
		end
		drain();
		build_file(FILE_HUGE_SKIP, n);
		send_file(1'b1);
		drain();
		repeat (8)
			@(posedge clk);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
